FILE: rtl/ehdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ehdt_pkg;

   localparam int HANDLES = 64;
   localparam int FILTERS = 8;

   localparam int SLOT_W  = (HANDLES > 1) ? $clog2(HANDLES) : 1;
   localparam int FADDR_W = (HANDLES * FILTERS > 1) ? $clog2(HANDLES * FILTERS) : 1;
   localparam int FCNT_W  = 4;
   localparam int COUNT_W = 7;

   localparam logic [2:0] KIND_ALLOC   = 3'd0;
   localparam logic [2:0] KIND_FREE    = 3'd1;
   localparam logic [2:0] KIND_ADD     = 3'd2;
   localparam logic [2:0] KIND_DELIVER = 3'd3;
   localparam logic [2:0] KIND_STATS   = 3'd4;
   // codes with no operation behind them
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_NOSLOT = 3'd1;
   localparam logic [2:0] ST_BADH   = 3'd2;
   localparam logic [2:0] ST_EXISTS = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;

   localparam logic [15:0] MIN_FRAME = 16'd14;
   localparam logic [7:0]  ANY_IF    = 8'hFF;
   localparam logic [15:0] NO_HANDLE = 16'h0000;

   typedef struct packed {
      logic [2:0]         status;
      logic [15:0]        result_handle;
      logic               matched;
      logic [COUNT_W-1:0] delivery_count;
      logic [31:0]        rx_pkts;
      logic [31:0]        rx_bytes;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [15:0]       id;
      logic [7:0]        ifc;
      logic [FCNT_W-1:0] fcnt;
   } slot_type;

   typedef struct packed {
      logic [31:0] pkts;
      logic [31:0] bytes;
   } counter_type;

   typedef enum logic [4:0] {
      S_IDLE, S_ID_RD, S_ID_CHK, S_FIND_RD, S_FIND_CHK, S_ADD_RD, S_ADD_CHK,
      S_ADD_END, S_STAT_RD, S_STAT_OUT, S_D_RD, S_D_CHK, S_DF_RD, S_DF_CHK,
      S_DC_RD, S_DC_UPD, S_D_NEXT, S_EMIT
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/ehdt_rsp_buf.sv
`timescale 1ns / 1ps
`default_nettype none
module ehdt_rsp_buf (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   output logic              in_ready,
   input  ehdt_pkg::rsp_type in_data,
   output logic              out_valid,
   input  wire               out_ready,
   output ehdt_pkg::rsp_type out_data
);
   logic              full_ff;
   ehdt_pkg::rsp_type data_ff;

   assign in_ready  = !full_ff || out_ready;
   assign out_valid = full_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         full_ff <= 1'b1;
      end else if (out_ready) begin
         full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/ethertype_handle_demux_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  ports        payload
// request  req_t*       kind on req_tuser; etype, src_ifc, hnd_id, frame_length
// response rsp_t*       status, result_handle, matched, delivery_count, rx_pkts,
//                       rx_bytes; last on rsp_tlast
//
// A sequencer reads the slot memory (registered reads) slot by slot, with an extra
// step per slot on deliver, plus a read and check per filter, a counter read and update
// and an emit per response; allocate scans every slot per candidate, lookups up to all.
// Reset: synchronous; clears the valid bits and counts at once, no clearing pass.
// Stalls: a one-entry output register takes each response, so the next request gets
// in while it waits; the sequencer stalls only when it has another response to push.
module ethertype_handle_demux_table_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // kind[2:0]
   input  wire  [2:0]  req_tuser,
   // etype[15:0], src_ifc[23:16], hnd_id[39:24], frame_length[55:40]
   input  wire  [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // status[2:0], result_handle[18:3], matched[19], delivery_count[26:20],
   // rx_pkts[58:27], rx_bytes[90:59], zero fill
   output logic [95:0] rsp_tdata,
   output logic        rsp_tlast
);
   localparam int SW = ehdt_pkg::SLOT_W;
   localparam int FW = ehdt_pkg::FADDR_W;
   localparam int CW = ehdt_pkg::FCNT_W;
   localparam int NW = ehdt_pkg::COUNT_W;

   logic [2:0]  req_kind;
   logic [15:0] req_ptype, req_hid, req_flen;
   logic [7:0]  req_ifn;
   assign req_kind  = req_tuser;
   assign req_ptype = req_tdata[15:0];
   assign req_ifn   = req_tdata[23:16];
   assign req_hid   = req_tdata[39:24];
   assign req_flen  = req_tdata[55:40];

   ehdt_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [SW-1:0] idx_ff, idx_in, slot_ff, slot_in;
   logic [CW-1:0] fidx_ff, fidx_in;
   logic [15:0]   cand_ff, cand_in, next_id_ff, next_id_in;
   logic [2:0]    kind_ff, kind_in;
   logic [15:0]   ptype_ff, ptype_in, hid_ff, hid_in, flen_ff, flen_in;
   logic [7:0]    ifn_ff, ifn_in;
   ehdt_pkg::slot_type sdata_ff, sdata_in;
   logic          pend_ff, pend_in;
   logic [15:0]   pend_h_ff, pend_h_in;
   logic [NW-1:0] n_ff, n_in, act_cnt_ff, act_cnt_in, peak_ff, peak_in;
   logic [ehdt_pkg::HANDLES-1:0] active_ff, active_in;
   ehdt_pkg::rsp_type res_ff, res_in, buf_out;
   logic buf_valid, buf_ready;

   // memories
   ehdt_pkg::slot_type    slot_mem [ehdt_pkg::HANDLES];
   logic [15:0]           filt_mem [ehdt_pkg::HANDLES * ehdt_pkg::FILTERS];
   ehdt_pkg::counter_type cnt_mem  [ehdt_pkg::HANDLES];
   ehdt_pkg::slot_type    slot_rd_ff;
   logic [15:0]           filt_rd_ff;
   ehdt_pkg::counter_type cnt_rd_ff;

   logic slot_we, filt_we, cnt_we;
   logic [SW-1:0] slot_wa, slot_ra, cnt_wa, cnt_ra;
   logic [FW-1:0] filt_wa, filt_ra;
   ehdt_pkg::slot_type    slot_wd;
   logic [15:0]           filt_wd;
   ehdt_pkg::counter_type cnt_wd;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_rd_ff <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (filt_we) begin
         filt_mem[filt_wa] <= filt_wd;
      end
      filt_rd_ff <= filt_mem[filt_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= cnt_mem[cnt_ra];
   end

   // lowest free slot
   logic [SW-1:0] free_idx;
   always_comb begin
      free_idx = '0;
      for (int i = ehdt_pkg::HANDLES - 1; i >= 0; i--) begin
         if (!active_ff[i]) free_idx = SW'(i);
      end
   end

   logic [CW-1:0] fcnt_lim;
   assign fcnt_lim = (sdata_ff.fcnt > CW'(ehdt_pkg::FILTERS)) ?
                     CW'(ehdt_pkg::FILTERS) : sdata_ff.fcnt;

   logic [FW-1:0] slot_fbase, idx_fbase;
   assign slot_fbase = FW'(slot_ff) * FW'(ehdt_pkg::FILTERS);
   assign idx_fbase  = FW'(idx_ff) * FW'(ehdt_pkg::FILTERS);

   logic idx_last;
   assign idx_last = (idx_ff == SW'(ehdt_pkg::HANDLES - 1));

   logic [15:0] cand_inc;
   assign cand_inc = cand_ff + 16'd1;

   assign req_tready = (state_ff == ehdt_pkg::S_IDLE);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      idx_in     = idx_ff;
      slot_in    = slot_ff;
      fidx_in    = fidx_ff;
      cand_in    = cand_ff;
      next_id_in = next_id_ff;
      kind_in    = kind_ff;
      ptype_in   = ptype_ff;
      hid_in     = hid_ff;
      flen_in    = flen_ff;
      ifn_in     = ifn_ff;
      sdata_in   = sdata_ff;
      pend_in    = pend_ff;
      pend_h_in  = pend_h_ff;
      n_in       = n_ff;
      act_cnt_in = act_cnt_ff;
      peak_in    = peak_ff;
      active_in  = active_ff;
      res_in     = res_ff;
      buf_valid  = 1'b0;
      slot_we = 1'b0; slot_wa = slot_ff; slot_wd = sdata_ff; slot_ra = idx_ff;
      filt_we = 1'b0; filt_wa = slot_fbase; filt_wd = ptype_ff; filt_ra = idx_fbase;
      cnt_we  = 1'b0; cnt_wa = idx_ff; cnt_wd = '0; cnt_ra = idx_ff;

      case (state_ff)
         ehdt_pkg::S_IDLE: begin
            res_in      = '0;
            res_in.last = 1'b1;
            ret_in      = ehdt_pkg::S_IDLE;
            idx_in      = '0;
            if (req_tvalid) begin
               kind_in  = req_kind;
               ptype_in = req_ptype;
               hid_in   = req_hid;
               flen_in  = req_flen;
               ifn_in   = req_ifn;
               state_in = ehdt_pkg::S_EMIT;
               case (req_kind)
                  ehdt_pkg::KIND_ALLOC: begin
                     if (&active_ff) begin
                        res_in.status = ehdt_pkg::ST_NOSLOT;
                     end else begin
                        slot_in  = free_idx;
                        cand_in  = (next_id_ff == ehdt_pkg::NO_HANDLE) ? 16'd1 : next_id_ff;
                        state_in = ehdt_pkg::S_ID_RD;
                     end
                  end
                  ehdt_pkg::KIND_FREE, ehdt_pkg::KIND_ADD, ehdt_pkg::KIND_STATS: begin
                     if (req_hid == ehdt_pkg::NO_HANDLE) begin
                        res_in.status = ehdt_pkg::ST_BADH;
                     end else begin
                        state_in = ehdt_pkg::S_FIND_RD;
                     end
                  end
                  ehdt_pkg::KIND_DELIVER: begin
                     n_in    = '0;
                     pend_in = 1'b0;
                     if (req_flen >= ehdt_pkg::MIN_FRAME) begin
                        state_in = ehdt_pkg::S_D_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ehdt_pkg::S_ID_RD: state_in = ehdt_pkg::S_ID_CHK;
         ehdt_pkg::S_ID_CHK: begin
            if (active_ff[idx_ff] && slot_rd_ff.id == cand_ff) begin
               // candidate taken: try the next one, never zero
               cand_in  = (cand_inc == ehdt_pkg::NO_HANDLE) ? 16'd1 : cand_inc;
               idx_in   = '0;
               state_in = ehdt_pkg::S_ID_RD;
            end else if (idx_last) begin
               slot_we    = 1'b1;
               slot_wd.id = cand_ff; slot_wd.ifc = ifn_ff; slot_wd.fcnt = CW'(1);
               filt_we    = 1'b1;
               cnt_we     = 1'b1;
               cnt_wa     = slot_ff;
               active_in[slot_ff] = 1'b1;
               next_id_in = cand_inc;
               act_cnt_in = act_cnt_ff + NW'(1);
               if (act_cnt_in > peak_ff) peak_in = act_cnt_in;
               res_in.result_handle = cand_ff;
               state_in = ehdt_pkg::S_EMIT;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = ehdt_pkg::S_ID_RD;
            end
         end
         ehdt_pkg::S_FIND_RD: state_in = ehdt_pkg::S_FIND_CHK;
         ehdt_pkg::S_FIND_CHK: begin
            if (active_ff[idx_ff] && slot_rd_ff.id == hid_ff) begin
               slot_in  = idx_ff;
               sdata_in = slot_rd_ff;
               fidx_in  = '0;
               case (kind_ff)
                  ehdt_pkg::KIND_FREE: begin
                     active_in[idx_ff] = 1'b0;
                     if (act_cnt_ff != '0) act_cnt_in = act_cnt_ff - NW'(1);
                     state_in = ehdt_pkg::S_EMIT;
                  end
                  ehdt_pkg::KIND_ADD: state_in = ehdt_pkg::S_ADD_RD;
                  default: state_in = ehdt_pkg::S_STAT_RD;
               endcase
            end else if (idx_last) begin
               res_in.status = ehdt_pkg::ST_BADH;
               state_in      = ehdt_pkg::S_EMIT;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = ehdt_pkg::S_FIND_RD;
            end
         end
         ehdt_pkg::S_ADD_RD: begin
            filt_ra  = slot_fbase + FW'(fidx_ff);
            state_in = (fcnt_lim == '0) ? ehdt_pkg::S_ADD_END : ehdt_pkg::S_ADD_CHK;
         end
         ehdt_pkg::S_ADD_CHK: begin
            if (filt_rd_ff == ptype_ff) begin
               res_in.status = ehdt_pkg::ST_EXISTS;
               state_in      = ehdt_pkg::S_EMIT;
            end else if (fidx_ff + CW'(1) >= fcnt_lim) begin
               state_in = ehdt_pkg::S_ADD_END;
            end else begin
               fidx_in  = fidx_ff + CW'(1);
               state_in = ehdt_pkg::S_ADD_RD;
            end
         end
         ehdt_pkg::S_ADD_END: begin
            if (fcnt_lim >= CW'(ehdt_pkg::FILTERS)) begin
               res_in.status = ehdt_pkg::ST_FULL;
            end else begin
               filt_we      = 1'b1;
               filt_wa      = slot_fbase + FW'(fcnt_lim);
               slot_we      = 1'b1;
               slot_wd.fcnt = fcnt_lim + CW'(1);
            end
            state_in = ehdt_pkg::S_EMIT;
         end
         ehdt_pkg::S_STAT_RD: begin
            cnt_ra   = slot_ff;
            state_in = ehdt_pkg::S_STAT_OUT;
         end
         ehdt_pkg::S_STAT_OUT: begin
            res_in.rx_pkts  = cnt_rd_ff.pkts;
            res_in.rx_bytes = cnt_rd_ff.bytes;
            state_in        = ehdt_pkg::S_EMIT;
         end
         ehdt_pkg::S_D_RD: state_in = ehdt_pkg::S_D_CHK;
         ehdt_pkg::S_D_CHK: begin
            sdata_in = slot_rd_ff;
            fidx_in  = '0;
            if (active_ff[idx_ff] && slot_rd_ff.fcnt != '0 &&
                (slot_rd_ff.ifc == ifn_ff || slot_rd_ff.ifc == ehdt_pkg::ANY_IF)) begin
               state_in = ehdt_pkg::S_DF_RD;
            end else begin
               state_in = ehdt_pkg::S_D_NEXT;
            end
         end
         ehdt_pkg::S_DF_RD: begin
            filt_ra  = idx_fbase + FW'(fidx_ff);
            state_in = ehdt_pkg::S_DF_CHK;
         end
         ehdt_pkg::S_DF_CHK: begin
            if (filt_rd_ff == 16'h0000 || filt_rd_ff == ptype_ff) begin
               state_in = ehdt_pkg::S_DC_RD;
            end else if (fidx_ff + CW'(1) >= fcnt_lim) begin
               state_in = ehdt_pkg::S_D_NEXT;
            end else begin
               fidx_in  = fidx_ff + CW'(1);
               state_in = ehdt_pkg::S_DF_RD;
            end
         end
         ehdt_pkg::S_DC_RD: state_in = ehdt_pkg::S_DC_UPD;
         ehdt_pkg::S_DC_UPD: begin
            cnt_we       = 1'b1;
            cnt_wd.pkts  = cnt_rd_ff.pkts + 32'd1;
            cnt_wd.bytes = cnt_rd_ff.bytes + 32'(flen_ff);
            n_in         = n_ff + NW'(1);
            pend_in      = 1'b1;
            pend_h_in    = sdata_ff.id;
            // hold one match back so the final one can carry last
            if (pend_ff) begin
               res_in                = '0;
               res_in.result_handle  = pend_h_ff;
               res_in.matched        = 1'b1;
               res_in.delivery_count = n_ff;
               ret_in                = ehdt_pkg::S_D_NEXT;
               state_in              = ehdt_pkg::S_EMIT;
            end else begin
               state_in = ehdt_pkg::S_D_NEXT;
            end
         end
         ehdt_pkg::S_D_NEXT: begin
            if (idx_last) begin
               res_in      = '0;
               res_in.last = 1'b1;
               if (pend_ff) begin
                  res_in.result_handle  = pend_h_ff;
                  res_in.matched        = 1'b1;
                  res_in.delivery_count = n_ff;
               end
               ret_in   = ehdt_pkg::S_IDLE;
               state_in = ehdt_pkg::S_EMIT;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = ehdt_pkg::S_D_RD;
            end
         end
         ehdt_pkg::S_EMIT: begin
            buf_valid = 1'b1;
            if (buf_ready) state_in = ret_ff;
         end
         default: state_in = ehdt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ehdt_pkg::S_IDLE;
         ret_ff     <= ehdt_pkg::S_IDLE;
         active_ff  <= '0;
         next_id_ff <= 16'd1;
         act_cnt_ff <= '0;
         peak_ff    <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         active_ff  <= active_in;
         next_id_ff <= next_id_in;
         act_cnt_ff <= act_cnt_in;
         peak_ff    <= peak_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      slot_ff   <= slot_in;
      fidx_ff   <= fidx_in;
      cand_ff   <= cand_in;
      kind_ff   <= kind_in;
      ptype_ff  <= ptype_in;
      hid_ff    <= hid_in;
      flen_ff   <= flen_in;
      ifn_ff    <= ifn_in;
      sdata_ff  <= sdata_in;
      pend_h_ff <= pend_h_in;
      n_ff      <= n_in;
      res_ff    <= res_in;
   end

   ehdt_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (buf_valid),
      .in_ready  (buf_ready),
      .in_data   (res_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buf_out)
   );

   assign rsp_tdata = {5'b0, buf_out.rx_bytes, buf_out.rx_pkts, buf_out.delivery_count,
                       buf_out.matched, buf_out.result_handle, buf_out.status};
   assign rsp_tlast = buf_out.last;

`ifndef NO_ASSERTIONS
   a_active_count: assert property (@(posedge clock) disable iff (reset)
      act_cnt_ff == NW'($countones(active_ff)))
      else $error("active count out of step with slot valid bits");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= act_cnt_ff)
      else $error("peak count below active count");
   a_match_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && buf_out.matched |-> buf_out.result_handle != ehdt_pkg::NO_HANDLE)
      else $error("matched response without a handle");
`endif
endmodule
`default_nettype wire
